// ----- src/rpli_pkg.sv -----
package rpli_pkg;

    // table dimensions
    localparam int MAX_ELEVATIONS = 32;
    localparam int MAX_GATES      = 1024;
    localparam int MAX_AZIMUTHS   = 1024;

    // fixed field widths
    localparam int OP_W      = 2;
    localparam int ELEV_W    = 5;
    localparam int SLOT_W    = 10;
    localparam int AZ_IN_W   = 16;
    localparam int RANGE_W   = 20;
    localparam int VAL_W     = 20;
    localparam int START_W   = 17;
    localparam int STEP_W    = 24;
    localparam int CNT_REG_W = 11;
    localparam int INDEX_W   = 32;

    // derived widths
    localparam int GATE_W     = $clog2(MAX_GATES);
    localparam int G_CNT_W    = $clog2(MAX_GATES + 1);
    localparam int A_CNT_W    = $clog2(MAX_AZIMUTHS + 1);
    localparam int GR_ADDR_W  = $clog2(MAX_ELEVATIONS * MAX_GATES);
    localparam int SEC_ADDR_W = (MAX_ELEVATIONS > 1) ? $clog2(MAX_ELEVATIONS) : 1;
    localparam int ROW_W      = ELEV_W + A_CNT_W;

    // datapath widths
    localparam int DIFF_W    = AZ_IN_W + 2;
    localparam int AZ_PROD_W = DIFF_W + STEP_W + 1;
    localparam int AZ_W      = DIFF_W + 1;
    localparam int MUL_A_W   = 20;
    localparam int MUL_P_W   = MUL_A_W + STEP_W;
    localparam int PROD_W    = RANGE_W + VAL_W;
    localparam int SUM_W     = MUL_P_W + 1;
    localparam int EST_W     = SUM_W - MUL_A_W;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_QUERY       = 2'd0,
        OP_LOAD_RANGE  = 2'd1,
        OP_LOAD_SECANT = 2'd2
    } op_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_START_AZIMUTH    = 3'd0,
        CFG_INV_AZIMUTH_STEP = 3'd1,
        CFG_NUM_AZIMUTHS     = 3'd2,
        CFG_NUM_GATES        = 3'd3,
        CFG_FIRST_GATE_RANGE = 3'd4,
        CFG_INV_GATE_STEP    = 3'd5,
        CFG_MISSING_INDEX    = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [START_W-1:0]   start_azimuth;
        logic [STEP_W-1:0]    inv_azimuth_step;
        logic [CNT_REG_W-1:0] num_azimuths;
        logic [CNT_REG_W-1:0] num_gates;
        logic [RANGE_W-1:0]   first_gate_range;
        logic [STEP_W-1:0]    inv_gate_step;
        logic [INDEX_W-1:0]   missing_index;
    } cfg_t;

    typedef struct packed {
        logic                  gr_en;
        logic                  gr_we;
        logic [GR_ADDR_W-1:0]  gr_addr;
        logic                  sec_en;
        logic                  sec_we;
        logic [SEC_ADDR_W-1:0] sec_addr;
        logic [VAL_W-1:0]      wdata;
    } tbl_req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ0,
        ST_READ1,
        ST_MUL,
        ST_SUB,
        ST_MULHI,
        ST_MULLO,
        ST_GATE,
        ST_ERR0,
        ST_DOWN,
        ST_UP,
        ST_DONE
    } ctrl_state_t;

    // flat address of a ground range entry
    function automatic logic [GR_ADDR_W-1:0] gr_addr_f(
        input logic [ELEV_W-1:0] e,
        input logic [GATE_W-1:0] g
    );
        logic [31:0] a;
        a = 32'(e) * 32'(MAX_GATES) + 32'(g);
        return a[GR_ADDR_W-1:0];
    endfunction

endpackage

// ----- src/rpli_tables.sv -----
module rpli_tables (
    input  logic                           aclk,
    input  rpli_pkg::tbl_req_t             req,
    output logic [rpli_pkg::VAL_W-1:0]     gr_rdata,
    output logic [rpli_pkg::VAL_W-1:0]     sec_rdata
);

    logic [rpli_pkg::VAL_W-1:0] gr_mem [rpli_pkg::MAX_ELEVATIONS * rpli_pkg::MAX_GATES];
    logic [rpli_pkg::VAL_W-1:0] sec_mem [rpli_pkg::MAX_ELEVATIONS];
    logic [rpli_pkg::VAL_W-1:0] gr_rdata_reg;
    logic [rpli_pkg::VAL_W-1:0] sec_rdata_reg;

    // ground range table, one port, registered read
    always_ff @(posedge aclk) begin
        if (req.gr_en) begin
            if (req.gr_we) begin
                gr_mem[req.gr_addr] <= req.wdata;
            end else begin
                gr_rdata_reg <= gr_mem[req.gr_addr];
            end
        end
    end

    // secant table, one port, registered read
    always_ff @(posedge aclk) begin
        if (req.sec_en) begin
            if (req.sec_we) begin
                sec_mem[req.sec_addr] <= req.wdata;
            end else begin
                sec_rdata_reg <= sec_mem[req.sec_addr];
            end
        end
    end

    assign gr_rdata  = gr_rdata_reg;
    assign sec_rdata = sec_rdata_reg;

endmodule

// ----- src/rpli_ctrl.sv -----
module rpli_ctrl (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rpli_pkg::cfg_t                     cfg,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [rpli_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    input  logic [rpli_pkg::OP_W-1:0]          s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [rpli_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    output logic                               m_axis_tuser,
    output rpli_pkg::tbl_req_t                 tbl_req,
    input  logic [rpli_pkg::VAL_W-1:0]         gr_rdata,
    input  logic [rpli_pkg::VAL_W-1:0]         sec_rdata
);

    rpli_pkg::ctrl_state_t state_reg, state_next;

    // input fields
    logic [rpli_pkg::ELEV_W-1:0]  in_elev;
    logic [rpli_pkg::SLOT_W-1:0]  in_slot;
    logic [rpli_pkg::AZ_IN_W-1:0] in_az;
    logic [rpli_pkg::RANGE_W-1:0] in_range;
    logic [rpli_pkg::VAL_W-1:0]   in_value;
    logic                         accept;
    logic                         elev_bad;
    logic                         slot_bad;

    // effective counts
    logic [rpli_pkg::A_CNT_W-1:0] na;
    logic [rpli_pkg::G_CNT_W-1:0] ng;
    logic [rpli_pkg::G_CNT_W-1:0] ng_m1;
    logic signed [rpli_pkg::AZ_W-1:0] na_s;

    // query datapath
    logic [rpli_pkg::ELEV_W-1:0]           elev_reg;
    logic [rpli_pkg::RANGE_W-1:0]          range_reg;
    logic signed [rpli_pkg::DIFF_W-1:0]    d_reg;
    logic signed [rpli_pkg::AZ_PROD_W-1:0] az_prod_reg;
    logic signed [rpli_pkg::AZ_W-1:0]      a_reg;
    logic signed [rpli_pkg::AZ_W-1:0]      aw_reg;
    logic [rpli_pkg::A_CNT_W-1:0]          az_reg;
    logic [rpli_pkg::ROW_W-1:0]            row_reg;
    logic [rpli_pkg::INDEX_W-1:0]          rowg_reg;
    logic [rpli_pkg::VAL_W-1:0]            gr0_reg;
    logic [rpli_pkg::VAL_W-1:0]            sec_reg;
    logic [rpli_pkg::PROD_W-1:0]           prod_reg;
    logic [rpli_pkg::PROD_W-1:0]           x_reg;
    logic [rpli_pkg::MUL_P_W-1:0]          ph_reg;
    logic [rpli_pkg::MUL_P_W-1:0]          pl_reg;

    // shared multiplier
    logic [rpli_pkg::MUL_A_W-1:0] mul_a;
    logic [rpli_pkg::STEP_W-1:0]  mul_b;
    logic [rpli_pkg::MUL_P_W-1:0] mul_p;

    // gate search
    logic [rpli_pkg::SUM_W-1:0]   est_sum;
    logic [rpli_pkg::EST_W-1:0]   est_raw;
    logic [rpli_pkg::GATE_W-1:0]  gate_est;
    logic [rpli_pkg::VAL_W-1:0]   err;
    logic                         gate_up_ok;
    logic                         probe_up_ok;
    logic [rpli_pkg::GATE_W-1:0]  gate_reg, gate_next;
    logic [rpli_pkg::GATE_W-1:0]  probe_reg, probe_next;
    logic [rpli_pkg::VAL_W-1:0]   err_min_reg, err_min_next;
    logic                         improved_reg, improved_next;
    logic                         outside_reg, outside_next;

    // result register
    logic                         m_valid_reg, m_valid_next;
    logic [rpli_pkg::INDEX_W-1:0] m_index_reg, m_index_next;
    logic                         m_outside_reg, m_outside_next;

    // unpack the input transaction
    assign in_elev  = s_axis_tdata[4:0];
    assign in_slot  = s_axis_tdata[14:5];
    assign in_az    = s_axis_tdata[30:15];
    assign in_range = s_axis_tdata[50:31];
    assign in_value = s_axis_tdata[70:51];
    assign s_axis_tready = (state_reg == rpli_pkg::ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign elev_bad = 32'(in_elev) >= 32'(rpli_pkg::MAX_ELEVATIONS);
    assign slot_bad = 32'(in_slot) >= 32'(rpli_pkg::MAX_GATES);

    // saturate the counts to 1 .. max
    always_comb begin
        if (cfg.num_azimuths == '0) begin
            na = rpli_pkg::A_CNT_W'(1);
        end else if (32'(cfg.num_azimuths) > 32'(rpli_pkg::MAX_AZIMUTHS)) begin
            na = rpli_pkg::A_CNT_W'(rpli_pkg::MAX_AZIMUTHS);
        end else begin
            na = rpli_pkg::A_CNT_W'(cfg.num_azimuths);
        end
        if (cfg.num_gates == '0) begin
            ng = rpli_pkg::G_CNT_W'(1);
        end else if (32'(cfg.num_gates) > 32'(rpli_pkg::MAX_GATES)) begin
            ng = rpli_pkg::G_CNT_W'(rpli_pkg::MAX_GATES);
        end else begin
            ng = rpli_pkg::G_CNT_W'(cfg.num_gates);
        end
    end

    assign ng_m1 = ng - rpli_pkg::G_CNT_W'(1);
    assign na_s  = $signed({{(rpli_pkg::AZ_W - rpli_pkg::A_CNT_W){1'b0}}, na});

    // multiplier operand select by step
    always_comb begin
        case (state_reg)
            rpli_pkg::ST_MULHI: begin
                mul_a = x_reg[rpli_pkg::PROD_W-1:rpli_pkg::MUL_A_W];
                mul_b = cfg.inv_gate_step;
            end
            rpli_pkg::ST_MULLO: begin
                mul_a = x_reg[rpli_pkg::MUL_A_W-1:0];
                mul_b = cfg.inv_gate_step;
            end
            default: begin
                mul_a = range_reg;
                mul_b = rpli_pkg::STEP_W'(sec_reg);
            end
        endcase
    end

    assign mul_p = rpli_pkg::MUL_P_W'(mul_a) * rpli_pkg::MUL_P_W'(mul_b);

    // start gate from the two partial products, clamped to the table
    assign est_sum  = rpli_pkg::SUM_W'(ph_reg)
                    + rpli_pkg::SUM_W'(pl_reg >> rpli_pkg::MUL_A_W);
    assign est_raw  = est_sum[rpli_pkg::SUM_W-1:rpli_pkg::MUL_A_W];
    assign gate_est = (est_raw > rpli_pkg::EST_W'(ng_m1)) ? rpli_pkg::GATE_W'(ng_m1)
                                                          : rpli_pkg::GATE_W'(est_raw);

    // absolute range error of the entry just read
    assign err = (range_reg >= gr_rdata) ? range_reg - gr_rdata : gr_rdata - range_reg;

    assign gate_up_ok  = (rpli_pkg::G_CNT_W'(gate_reg) + rpli_pkg::G_CNT_W'(1)) < ng;
    assign probe_up_ok = (rpli_pkg::G_CNT_W'(probe_reg) + rpli_pkg::G_CNT_W'(1)) < ng;

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            rpli_pkg::ST_IDLE: begin
                if (accept) begin
                    elev_reg  <= in_elev;
                    range_reg <= in_range;
                    d_reg     <= $signed({2'b00, in_az})
                               - $signed({cfg.start_azimuth[rpli_pkg::START_W-1],
                                          cfg.start_azimuth});
                end
            end
            rpli_pkg::ST_READ0: begin
                az_prod_reg <= d_reg * $signed({1'b0, cfg.inv_azimuth_step});
            end
            rpli_pkg::ST_READ1: begin
                a_reg   <= rpli_pkg::AZ_W'((az_prod_reg + rpli_pkg::AZ_PROD_W'(24'h80_0000))
                                           >>> 24);
                gr0_reg <= gr_rdata;
                sec_reg <= sec_rdata;
            end
            rpli_pkg::ST_MUL: begin
                prod_reg <= rpli_pkg::PROD_W'(mul_p);
                // single wrap by the azimuth count
                if (a_reg >= na_s) begin
                    aw_reg <= a_reg - na_s;
                end else if (a_reg < 0) begin
                    aw_reg <= a_reg + na_s;
                end else begin
                    aw_reg <= a_reg;
                end
            end
            rpli_pkg::ST_SUB: begin
                if (prod_reg > rpli_pkg::PROD_W'({cfg.first_gate_range, 16'h0000})) begin
                    x_reg <= prod_reg - rpli_pkg::PROD_W'({cfg.first_gate_range, 16'h0000});
                end else begin
                    x_reg <= '0;
                end
                // clamp the column to the table
                if (aw_reg < 0) begin
                    az_reg <= '0;
                end else if (aw_reg > na_s - rpli_pkg::AZ_W'(1)) begin
                    az_reg <= na - rpli_pkg::A_CNT_W'(1);
                end else begin
                    az_reg <= rpli_pkg::A_CNT_W'(aw_reg);
                end
            end
            rpli_pkg::ST_MULHI: begin
                ph_reg <= mul_p;
            end
            rpli_pkg::ST_MULLO: begin
                pl_reg <= mul_p;
            end
            rpli_pkg::ST_GATE: begin
                row_reg <= rpli_pkg::ROW_W'(rpli_pkg::ROW_W'(elev_reg) * rpli_pkg::ROW_W'(na))
                         + rpli_pkg::ROW_W'(az_reg);
            end
            rpli_pkg::ST_ERR0: begin
                rowg_reg <= rpli_pkg::INDEX_W'(rpli_pkg::INDEX_W'(row_reg)
                                             * rpli_pkg::INDEX_W'(ng));
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= rpli_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            improved_reg  <= 1'b0;
            outside_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            improved_reg  <= improved_next;
            outside_reg   <= outside_next;
        end
        gate_reg      <= gate_next;
        probe_reg     <= probe_next;
        err_min_reg   <= err_min_next;
        m_index_reg   <= m_index_next;
        m_outside_reg <= m_outside_next;
    end

    // sequencer: table accesses, hill-climb and result hand-off
    always_comb begin
        state_next     = state_reg;
        gate_next      = gate_reg;
        probe_next     = probe_reg;
        err_min_next   = err_min_reg;
        improved_next  = improved_reg;
        outside_next   = outside_reg;
        m_valid_next   = m_valid_reg;
        m_index_next   = m_index_reg;
        m_outside_next = m_outside_reg;
        tbl_req        = '0;
        tbl_req.wdata  = in_value;

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            rpli_pkg::ST_IDLE: begin
                if (accept) begin
                    case (s_axis_tuser)
                        rpli_pkg::OP_QUERY: begin
                            outside_next  = elev_bad;
                            improved_next = 1'b0;
                            state_next    = elev_bad ? rpli_pkg::ST_DONE : rpli_pkg::ST_READ0;
                        end
                        rpli_pkg::OP_LOAD_RANGE: begin
                            if (!elev_bad && !slot_bad) begin
                                tbl_req.gr_en   = 1'b1;
                                tbl_req.gr_we   = 1'b1;
                                tbl_req.gr_addr = rpli_pkg::gr_addr_f(in_elev,
                                                      rpli_pkg::GATE_W'(in_slot));
                            end
                        end
                        rpli_pkg::OP_LOAD_SECANT: begin
                            if (!elev_bad) begin
                                tbl_req.sec_en   = 1'b1;
                                tbl_req.sec_we   = 1'b1;
                                tbl_req.sec_addr = rpli_pkg::SEC_ADDR_W'(in_elev);
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rpli_pkg::ST_READ0: begin
                // first entry and secant
                tbl_req.gr_en    = 1'b1;
                tbl_req.gr_addr  = rpli_pkg::gr_addr_f(elev_reg, '0);
                tbl_req.sec_en   = 1'b1;
                tbl_req.sec_addr = rpli_pkg::SEC_ADDR_W'(elev_reg);
                state_next       = rpli_pkg::ST_READ1;
            end
            rpli_pkg::ST_READ1: begin
                // last entry in use
                tbl_req.gr_en   = 1'b1;
                tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, rpli_pkg::GATE_W'(ng_m1));
                state_next      = rpli_pkg::ST_MUL;
            end
            rpli_pkg::ST_MUL: begin
                // range check against the first and last entries
                if (range_reg < gr0_reg || range_reg > gr_rdata) begin
                    outside_next = 1'b1;
                    state_next   = rpli_pkg::ST_DONE;
                end else begin
                    state_next   = rpli_pkg::ST_SUB;
                end
            end
            rpli_pkg::ST_SUB: begin
                state_next = rpli_pkg::ST_MULHI;
            end
            rpli_pkg::ST_MULHI: begin
                state_next = rpli_pkg::ST_MULLO;
            end
            rpli_pkg::ST_MULLO: begin
                state_next = rpli_pkg::ST_GATE;
            end
            rpli_pkg::ST_GATE: begin
                gate_next       = gate_est;
                tbl_req.gr_en   = 1'b1;
                tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, gate_est);
                state_next      = rpli_pkg::ST_ERR0;
            end
            rpli_pkg::ST_ERR0: begin
                // error at the start gate, then try shorter gates first
                err_min_next = err;
                if (gate_reg != '0) begin
                    probe_next      = gate_reg - rpli_pkg::GATE_W'(1);
                    tbl_req.gr_en   = 1'b1;
                    tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, probe_next);
                    state_next      = rpli_pkg::ST_DOWN;
                end else if (gate_up_ok) begin
                    probe_next      = gate_reg + rpli_pkg::GATE_W'(1);
                    tbl_req.gr_en   = 1'b1;
                    tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, probe_next);
                    state_next      = rpli_pkg::ST_UP;
                end else begin
                    state_next      = rpli_pkg::ST_DONE;
                end
            end
            rpli_pkg::ST_DOWN: begin
                if (err < err_min_reg) begin
                    gate_next     = probe_reg;
                    err_min_next  = err;
                    improved_next = 1'b1;
                    if (probe_reg == '0) begin
                        state_next = rpli_pkg::ST_DONE;
                    end else begin
                        probe_next      = probe_reg - rpli_pkg::GATE_W'(1);
                        tbl_req.gr_en   = 1'b1;
                        tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, probe_next);
                    end
                end else if (improved_reg) begin
                    state_next = rpli_pkg::ST_DONE;
                end else if (gate_up_ok) begin
                    // no gain going shorter, climb towards longer gates
                    probe_next      = gate_reg + rpli_pkg::GATE_W'(1);
                    tbl_req.gr_en   = 1'b1;
                    tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, probe_next);
                    state_next      = rpli_pkg::ST_UP;
                end else begin
                    state_next = rpli_pkg::ST_DONE;
                end
            end
            rpli_pkg::ST_UP: begin
                if (err < err_min_reg) begin
                    gate_next    = probe_reg;
                    err_min_next = err;
                    if (probe_up_ok) begin
                        probe_next      = probe_reg + rpli_pkg::GATE_W'(1);
                        tbl_req.gr_en   = 1'b1;
                        tbl_req.gr_addr = rpli_pkg::gr_addr_f(elev_reg, probe_next);
                    end else begin
                        state_next = rpli_pkg::ST_DONE;
                    end
                end else begin
                    state_next = rpli_pkg::ST_DONE;
                end
            end
            rpli_pkg::ST_DONE: begin
                // wait for the output register to free up
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next   = 1'b1;
                    m_outside_next = outside_reg;
                    m_index_next   = outside_reg ? cfg.missing_index
                                                 : rowg_reg + rpli_pkg::INDEX_W'(gate_reg);
                    state_next     = rpli_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rpli_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_index_reg;
    assign m_axis_tuser  = m_outside_reg;

endmodule

// ----- src/radar_ppi_lookup_index_unit.sv -----
// Polar table index lookup for a radar PPI scan.
// Slave stream: tuser carries the op (query, ground range load, secant load),
// tdata carries elevation, gate slot, azimuth, ground range and load value.
// Master stream: tdata is the flat table index, tuser the outside flag.
// Loads write the ground range or secant table in the accept cycle and give
// no result; the next transaction can be taken in the following cycle.
// A query runs from accept through table reads, multiplies, the start gate
// read and the hill-climb probes to the result register; the gate search reads
// the ground range memory one entry per cycle through its single port, and one
// item is in work at a time. Tables must be loaded before a query reads them.
// The result stays on the master side until taken; a new transaction is
// accepted meanwhile, and a following query waits in its last step if the
// result register is still full.
// Configuration writes go through cfg_we/cfg_addr/cfg_wdata and must only
// happen while the unit is idle. Reset (aresetn low, synchronous) restores
// the register defaults and clears the sequencer; table contents are kept.
module radar_ppi_lookup_index_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [rpli_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rpli_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // elevation[4:0], gate_slot[14:5], azimuth[30:15], ground_range[50:31],
    // load_value[70:51], zero pad[71]
    input  logic [rpli_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // op[1:0]
    input  logic [rpli_pkg::OP_W-1:0]           s_axis_tuser,
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // table_index[31:0]
    output logic [rpli_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // outside[0]
    output logic                                m_axis_tuser
);

    rpli_pkg::cfg_t             cfg_reg;
    rpli_pkg::tbl_req_t         tbl_req;
    logic [rpli_pkg::VAL_W-1:0] gr_rdata;
    logic [rpli_pkg::VAL_W-1:0] sec_rdata;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_azimuth    <= '0;
            cfg_reg.inv_azimuth_step <= rpli_pkg::STEP_W'(167772);
            cfg_reg.num_azimuths     <= rpli_pkg::CNT_REG_W'(360);
            cfg_reg.num_gates        <= rpli_pkg::CNT_REG_W'(1024);
            cfg_reg.first_gate_range <= '0;
            cfg_reg.inv_gate_step    <= rpli_pkg::STEP_W'(67109);
            cfg_reg.missing_index    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rpli_pkg::CFG_START_AZIMUTH:
                    cfg_reg.start_azimuth <= cfg_wdata[rpli_pkg::START_W-1:0];
                rpli_pkg::CFG_INV_AZIMUTH_STEP:
                    cfg_reg.inv_azimuth_step <= cfg_wdata[rpli_pkg::STEP_W-1:0];
                rpli_pkg::CFG_NUM_AZIMUTHS:
                    cfg_reg.num_azimuths <= cfg_wdata[rpli_pkg::CNT_REG_W-1:0];
                rpli_pkg::CFG_NUM_GATES:
                    cfg_reg.num_gates <= cfg_wdata[rpli_pkg::CNT_REG_W-1:0];
                rpli_pkg::CFG_FIRST_GATE_RANGE:
                    cfg_reg.first_gate_range <= cfg_wdata[rpli_pkg::RANGE_W-1:0];
                rpli_pkg::CFG_INV_GATE_STEP:
                    cfg_reg.inv_gate_step <= cfg_wdata[rpli_pkg::STEP_W-1:0];
                rpli_pkg::CFG_MISSING_INDEX:
                    cfg_reg.missing_index <= cfg_wdata[rpli_pkg::INDEX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ground range and secant memories
    rpli_tables u_tables (
        .aclk      (aclk),
        .req       (tbl_req),
        .gr_rdata  (gr_rdata),
        .sec_rdata (sec_rdata)
    );

    // sequencer and arithmetic
    rpli_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .tbl_req       (tbl_req),
        .gr_rdata      (gr_rdata),
        .sec_rdata     (sec_rdata)
    );

    // a query keeps the input side closed while it is worked on
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == rpli_pkg::OP_QUERY)
        |=> !s_axis_tready)
        else $error("input taken while a query is in work");

    // loads and unused ops leave the unit ready in the next cycle
    a_load_single_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser != rpli_pkg::OP_QUERY)
        |=> s_axis_tready)
        else $error("load transaction held the unit busy");

    // a new result only appears after a busy cycle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result raised without a query in work");

endmodule
